@@ rtl/core/fwbm_pkg.sv @@
// ----------------------------------------------------------------------------
// fwbm_pkg
// Shared types, character codes and classification functions for the
// forward word boundary marker.
// ----------------------------------------------------------------------------
package fwbm_pkg;

    localparam int POSITION_BITS = 16;

    localparam logic [15:0] CODE_JSPACE     = 16'h2121;
    localparam logic [15:0] CODE_LONG_VOWEL = 16'h213c;
    localparam logic [15:0] CODE_KATA_REP   = 16'h2133;
    localparam logic [15:0] CODE_KATA_REP_V = 16'h2134;
    localparam logic [15:0] CODE_HIRA_REP   = 16'h2135;
    localparam logic [15:0] CODE_HIRA_REP_V = 16'h2136;
    localparam logic [15:0] CODE_KANJI_REP  = 16'h2139;
    localparam logic [15:0] CODE_HIRA_WO    = 16'h2472;
    localparam logic [15:0] CODE_KANJI_LOW  = 16'h3000;
    localparam logic [15:0] ROW_MASK        = 16'h7f00;
    localparam logic [15:0] SINGLE_BYTE_MAX = 16'h00ff;
    localparam logic [15:0] ROW_KATA        = 16'h2500;
    localparam logic [15:0] ROW_HIRA        = 16'h2400;
    localparam logic [15:0] ROW_JASCII      = 16'h2300;
    localparam logic [15:0] CODE_SPACE      = 16'h0020;
    localparam logic [15:0] CODE_TAB        = 16'h0009;

    typedef enum logic [3:0] {
        CL_JUNK   = 4'd0,
        CL_SPACE  = 4'd1,
        CL_KANJI  = 4'd2,
        CL_KATA   = 4'd3,
        CL_HIRA   = 4'd4,
        CL_JASCII = 4'd5,
        CL_JPUNCT = 4'd6,
        CL_ASCII  = 4'd7,
        CL_APUNCT = 4'd8
    } class_t;

    typedef struct packed {
        logic [15:0] code;
        logic        restart;
        class_t      cls;
    } item_t;

    function automatic logic is_word_ascii(input logic [15:0] c);
        return (c >= 16'h0030 && c <= 16'h0039) || (c >= 16'h0041 && c <= 16'h005a) ||
               (c >= 16'h0061 && c <= 16'h007a) || c == 16'h005f || c == 16'h0040 ||
               c == 16'h0023 || c == 16'h0024 || c == 16'h0025;
    endfunction

    function automatic class_t class_of(input logic [15:0] c);
        logic [15:0] hi;
        class_t      cl;
        hi = c & ROW_MASK;
        if (c == 16'h0000)
            cl = CL_JUNK;
        else if (c >= CODE_KANJI_LOW)
            cl = CL_KANJI;
        else if (c == CODE_SPACE || c == CODE_TAB || c == CODE_JSPACE)
            cl = CL_SPACE;
        else if (hi == ROW_KATA)
            cl = CL_KATA;
        else if (hi == ROW_HIRA)
            cl = CL_HIRA;
        else if (hi == ROW_JASCII)
            cl = CL_JASCII;
        else if (c > SINGLE_BYTE_MAX)
            cl = CL_JPUNCT;
        else if (is_word_ascii(c))
            cl = CL_ASCII;
        else
            cl = CL_APUNCT;
        return cl;
    endfunction

    // a mark from {m1,m2} on either side joins when the other side is in {w1,w2}
    function automatic logic joins(input logic [15:0] a, input logic [15:0] b,
                                   input logic [15:0] m1, input logic [15:0] m2,
                                   input class_t ca, input class_t cb,
                                   input class_t w1, input class_t w2);
        class_t other;
        logic   hit;
        hit   = 1'b1;
        other = cb;
        if (a == m1 || a == m2)
            other = cb;
        else if (b == m1 || b == m2)
            other = ca;
        else
            hit = 1'b0;
        return hit && (other == w1 || other == w2);
    endfunction

    function automatic logic same_class(input logic [15:0] a, input logic [15:0] b);
        class_t ca;
        class_t cb;
        logic   same;
        ca = class_of(a);
        cb = class_of(b);
        if (a == CODE_HIRA_WO || b == CODE_HIRA_WO)
            same = 1'b0;
        else
            same = (ca == cb) ||
                   (ca == CL_SPACE && cb == CL_JUNK) || (cb == CL_SPACE && ca == CL_JUNK) ||
                   joins(a, b, CODE_LONG_VOWEL, CODE_LONG_VOWEL, ca, cb, CL_KATA, CL_HIRA) ||
                   joins(a, b, CODE_KANJI_REP, CODE_KANJI_REP, ca, cb, CL_KANJI, CL_KANJI) ||
                   joins(a, b, CODE_KATA_REP, CODE_KATA_REP_V, ca, cb, CL_KATA, CL_KATA) ||
                   joins(a, b, CODE_HIRA_REP, CODE_HIRA_REP_V, ca, cb, CL_HIRA, CL_HIRA);
        return same;
    endfunction

endpackage

@@ rtl/core/fwbm_front.sv @@
// ----------------------------------------------------------------------------
// fwbm_front
// Input stage: takes a character request, classifies it and holds it until
// the queue takes it.
// ----------------------------------------------------------------------------
module fwbm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [15:0]       jis_code,
    input  logic              restart,
    output logic              push_valid,
    input  logic              push_ready,
    output fwbm_pkg::item_t   push_item
);

    logic            valid_reg;
    logic            valid_next;
    fwbm_pkg::item_t item_reg;
    logic            accept;

    assign in_ready   = !valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.code    <= jis_code;
            item_reg.restart <= restart;
            item_reg.cls     <= fwbm_pkg::class_of(jis_code);
        end
    end

endmodule

@@ rtl/core/fwbm_queue.sv @@
// ----------------------------------------------------------------------------
// fwbm_queue
// Two-entry queue between the classifying front and the rule back end.
// ----------------------------------------------------------------------------
module fwbm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  fwbm_pkg::item_t   push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output fwbm_pkg::item_t   pop_item
);

    fwbm_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

@@ rtl/core/fwbm_back.sv @@
// ----------------------------------------------------------------------------
// fwbm_back
// Rule stage: applies the break rules against the previous and reference
// characters, tracks position and drives the result register.
// ----------------------------------------------------------------------------
module fwbm_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  fwbm_pkg::item_t   pop_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              word_start,
    output logic [3:0]        char_class,
    output logic [15:0]       char_position
);

    localparam logic [fwbm_pkg::POSITION_BITS-1:0] POS_MAX = '1;

    logic [15:0]                        prev_reg;
    logic [15:0]                        ref_reg;
    logic                               started_reg;
    logic [fwbm_pkg::POSITION_BITS-1:0] pos_reg;
    logic [fwbm_pkg::POSITION_BITS-1:0] pos_next;
    logic [15:0]                        ref_eff;
    logic [15:0]                        ref_next;
    logic [31:0]                        pos_wide;
    logic                               first;
    logic                               spacelike;
    logic                               stop;
    logic                               pop;

    logic                               out_valid_reg;
    logic                               word_start_reg;
    logic [3:0]                         char_class_reg;
    logic [15:0]                        char_position_reg;

    assign pop_ready = !out_valid_reg || out_ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        first     = pop_item.restart || !started_reg;
        // a long-vowel reference takes on the incoming character first
        ref_eff   = (ref_reg == fwbm_pkg::CODE_LONG_VOWEL) ? pop_item.code : ref_reg;
        spacelike = (pop_item.cls == fwbm_pkg::CL_SPACE) ||
                    (pop_item.cls == fwbm_pkg::CL_JUNK);
        stop      = first ||
                    ((!fwbm_pkg::same_class(prev_reg, pop_item.code) ||
                      !fwbm_pkg::same_class(ref_eff, pop_item.code)) && !spacelike);
        ref_next  = stop ? pop_item.code : ref_eff;
        if (first)
            pos_next = '0;
        else if (pos_reg == POS_MAX)
            pos_next = pos_reg;
        else
            pos_next = pos_reg + 1'b1;
        pos_wide  = 32'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            ref_reg       <= '0;
            started_reg   <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                prev_reg    <= pop_item.code;
                ref_reg     <= ref_next;
                started_reg <= 1'b1;
                pos_reg     <= pos_next;
            end
            if (pop)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            word_start_reg    <= stop;
            char_class_reg    <= pop_item.cls;
            char_position_reg <= pos_wide[15:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign word_start    = word_start_reg;
    assign char_class    = char_class_reg;
    assign char_position = char_position_reg;

endmodule

@@ rtl/core/forward_word_boundary_marker.sv @@
// ----------------------------------------------------------------------------
// forward_word_boundary_marker
// Classifies a stream of JIS/ASCII character codes and marks forward word stops.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one character code per request, with
//   restart set on the character where navigation begins anew. The first
//   request after reset is always treated as a restart.
//   Output channel (out_valid/out_ready): one result per input request, in
//   order: word_start, char_class and char_position (saturating count since
//   the last restart, low 16 bits shown).
//   Throughput: one character per cycle unless the receiver stalls. The
//   front stage classifies, a two-entry queue feeds the rule stage, whose
//   previous/reference registers update in the same cycle they are read.
//   Path: front register, two-entry queue, then the result register (out_valid).
//   Stall: a stalled receiver holds the result register; the queue and the
//   front register absorb three more requests before in_ready drops.
//   Reset: asynchronous, active low; clears all valid flags and the
//   previous/reference/position state. No clearing pass is needed.
// ----------------------------------------------------------------------------
module forward_word_boundary_marker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] jis_code,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        word_start,
    output logic [3:0]  char_class,
    output logic [15:0] char_position
);

    logic            push_valid;
    logic            push_ready;
    fwbm_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    fwbm_pkg::item_t pop_item;

    fwbm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .jis_code   (jis_code),
        .restart    (restart),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    fwbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fwbm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word_start    (word_start),
        .char_class    (char_class),
        .char_position (char_position)
    );

endmodule

@@ rtl/core/fwbm_checker.sv @@
// ----------------------------------------------------------------------------
// fwbm_checker
// Port-level checks for the forward word boundary marker.
// ----------------------------------------------------------------------------
module fwbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        word_start,
    input logic [3:0]  char_class,
    input logic [15:0] char_position
);

    // a result waiting on the receiver keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_start) &&
        $stable(char_class) && $stable(char_position))
        else $error("result changed while stalled");

    // position zero only comes from a restart, which is always a stop
    a_pos0_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_position == 16'd0 |-> word_start)
        else $error("restart result not marked as word start");

    // spacelike characters past a restart never stop navigation
    a_space_nostop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && char_position != 16'd0 &&
        (char_class == fwbm_pkg::CL_SPACE || char_class == fwbm_pkg::CL_JUNK)
        |-> !word_start)
        else $error("spacelike character marked as word start");

    // in_ready is always up when the pipe is drained after reset release
    a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready)
        else $error("input not ready after reset");

endmodule

bind forward_word_boundary_marker fwbm_checker u_fwbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .word_start    (word_start),
    .char_class    (char_class),
    .char_position (char_position)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for forward_word_boundary_marker. A scoreboard keeps its
// own model of the word-stop rules (class, previous and reference character,
// saturating position) and checks every result against the oldest prediction.
// Stimulus: a directed pass over the rule corner cases, one long run that
// restarts only on its first character and has no idling, and then random
// word-shaped text. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 9;
    localparam int RANDOM_ITEMS = 1475;
    localparam int SAT_ITEMS   = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 8;

    typedef enum logic [1:0] {
        MK_LONG,
        MK_KANJI,
        MK_KATA,
        MK_HIRA
    } mark_t;

    typedef struct {
        bit                stop;
        fwbm_pkg::class_t  cls;
        logic [15:0]       pos;
    } stop_result_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [15:0] jis_code      = '0;
    logic        restart       = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic        word_start;
    logic [3:0]  char_class;
    logic [15:0] char_position;

    bit          calm          = 1'b0;
    int          quiet_cycles  = 0;

    always #4 clk = ~clk;

    forward_word_boundary_marker i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .jis_code      (jis_code),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .word_start    (word_start),
        .char_class    (char_class),
        .char_position (char_position)
    );

    class word_stop_board;
        stop_result_t                        stops_due[$];
        int                                  mismatches = 0;
        logic [15:0]                         last_code  = '0;
        logic [15:0]                         ref_code   = '0;
        bit                                  begun      = 1'b0;
        logic [fwbm_pkg::POSITION_BITS-1:0]  pos_count  = '0;

        function automatic fwbm_pkg::class_t word_class(logic [15:0] c);
            logic [7:0] b;
            b = c[7:0];
            if (c == 16'h0000)
                return fwbm_pkg::CL_JUNK;
            if (c >= fwbm_pkg::CODE_KANJI_LOW)
                return fwbm_pkg::CL_KANJI;
            if (c == fwbm_pkg::CODE_SPACE || c == fwbm_pkg::CODE_TAB ||
                c == fwbm_pkg::CODE_JSPACE)
                return fwbm_pkg::CL_SPACE;
            unique case (c & fwbm_pkg::ROW_MASK)
                fwbm_pkg::ROW_KATA:   return fwbm_pkg::CL_KATA;
                fwbm_pkg::ROW_HIRA:   return fwbm_pkg::CL_HIRA;
                fwbm_pkg::ROW_JASCII: return fwbm_pkg::CL_JASCII;
                default:              ;
            endcase
            if (c > fwbm_pkg::SINGLE_BYTE_MAX)
                return fwbm_pkg::CL_JPUNCT;
            if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                (b >= "a" && b <= "z") || b == "_" || b == "@" ||
                b == "#" || b == "$" || b == "%")
                return fwbm_pkg::CL_ASCII;
            return fwbm_pkg::CL_APUNCT;
        endfunction

        function automatic bit is_mark(logic [15:0] c, mark_t m);
            unique case (m)
                MK_LONG:  return c == fwbm_pkg::CODE_LONG_VOWEL;
                MK_KANJI: return c == fwbm_pkg::CODE_KANJI_REP;
                MK_KATA:  return c == fwbm_pkg::CODE_KATA_REP ||
                                 c == fwbm_pkg::CODE_KATA_REP_V;
                default:  return c == fwbm_pkg::CODE_HIRA_REP ||
                                 c == fwbm_pkg::CODE_HIRA_REP_V;
            endcase
        endfunction

        function automatic bit mark_takes(mark_t m, fwbm_pkg::class_t partner);
            unique case (m)
                MK_LONG:  return partner == fwbm_pkg::CL_KATA ||
                                 partner == fwbm_pkg::CL_HIRA;
                MK_KANJI: return partner == fwbm_pkg::CL_KANJI;
                MK_KATA:  return partner == fwbm_pkg::CL_KATA;
                default:  return partner == fwbm_pkg::CL_HIRA;
            endcase
        endfunction

        // the left-hand mark wins when both sides belong to the same family
        function automatic bit mark_join(logic [15:0] a, logic [15:0] b,
                                         fwbm_pkg::class_t ca, fwbm_pkg::class_t cb,
                                         mark_t m);
            if (is_mark(a, m))
                return mark_takes(m, cb);
            if (is_mark(b, m))
                return mark_takes(m, ca);
            return 1'b0;
        endfunction

        function automatic bit same_word(logic [15:0] a, logic [15:0] b);
            fwbm_pkg::class_t ca;
            fwbm_pkg::class_t cb;
            ca = word_class(a);
            cb = word_class(b);
            if (a == fwbm_pkg::CODE_HIRA_WO || b == fwbm_pkg::CODE_HIRA_WO)
                return 1'b0;
            if (ca == cb)
                return 1'b1;
            if ((ca == fwbm_pkg::CL_SPACE || ca == fwbm_pkg::CL_JUNK) &&
                (cb == fwbm_pkg::CL_SPACE || cb == fwbm_pkg::CL_JUNK))
                return 1'b1;
            return mark_join(a, b, ca, cb, MK_LONG) || mark_join(a, b, ca, cb, MK_KANJI) ||
                   mark_join(a, b, ca, cb, MK_KATA) || mark_join(a, b, ca, cb, MK_HIRA);
        endfunction

        function void note_char(logic [15:0] c, logic rs);
            stop_result_t r;
            r.cls = word_class(c);
            if (rs || !begun)
            begin
                begun     = 1'b1;
                pos_count = '0;
                last_code = c;
                ref_code  = c;
                r.stop    = 1'b1;
            end
            else
            begin
                if (pos_count != '1)
                    pos_count++;
                if (ref_code == fwbm_pkg::CODE_LONG_VOWEL)
                    ref_code = c;
                r.stop = (!same_word(last_code, c) || !same_word(ref_code, c)) &&
                         r.cls != fwbm_pkg::CL_SPACE && r.cls != fwbm_pkg::CL_JUNK;
                if (r.stop)
                    ref_code = c;
                last_code = c;
            end
            r.pos = pos_count[15:0];
            stops_due.push_back(r);
        endfunction

        task report(string what);
            mismatches++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_result(logic ws, logic [3:0] cls, logic [15:0] pos);
            stop_result_t e;
            if (stops_due.size() == 0)
            begin
                report($sformatf("unexpected result ws=%0b class=%0d pos=%0d", ws, cls, pos));
                return;
            end
            e = stops_due.pop_front();
            if (ws !== e.stop)
                report($sformatf("word_start %0b, want %0b (pos %0d)", ws, e.stop, e.pos));
            if (cls !== 4'(e.cls))
                report($sformatf("char_class %0d, want %0d (pos %0d)", cls, e.cls, e.pos));
            if (pos !== e.pos)
                report($sformatf("char_position %0d, want %0d", pos, e.pos));
        endtask
    endclass

    word_stop_board board = new();

    task automatic send_char(logic [15:0] c, logic rs);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        jis_code <= c;
        restart  <= rs;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_char(c, rs);
    endtask

    // text-like code of a given flavor; flavor 9 is any 16-bit value
    function automatic logic [15:0] pick_code(int flavor);
        logic [15:0] marks[7];
        logic [15:0] blanks[4];
        marks  = '{fwbm_pkg::CODE_LONG_VOWEL, fwbm_pkg::CODE_KATA_REP,
                   fwbm_pkg::CODE_KATA_REP_V, fwbm_pkg::CODE_HIRA_REP,
                   fwbm_pkg::CODE_HIRA_REP_V, fwbm_pkg::CODE_KANJI_REP,
                   fwbm_pkg::CODE_HIRA_WO};
        blanks = '{fwbm_pkg::CODE_SPACE, fwbm_pkg::CODE_TAB, fwbm_pkg::CODE_JSPACE,
                   16'h0000};
        unique case (flavor)
            0:       return 16'($urandom_range(16'hffff, 16'h3000));
            1:       return fwbm_pkg::ROW_KATA | 16'($urandom_range(255));
            2:       return fwbm_pkg::ROW_HIRA | 16'($urandom_range(255));
            3:       return fwbm_pkg::ROW_JASCII | 16'($urandom_range(255));
            4:       return marks[$urandom_range(6)];
            5:       return 16'($urandom_range(16'h7a, 16'h30));
            6:       return 16'($urandom_range(16'hff, 16'h01));
            7:       return blanks[$urandom_range(3)];
            8:       return 16'($urandom_range(16'h2fff, 16'h0100));
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(word_start, char_class, char_position);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    initial
    begin
        int sent;
        int flavor;
        int run;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first character starts a word even without restart
        send_char(16'h0041, 1'b0);
        send_char(16'h0062, 1'b0);
        send_char(fwbm_pkg::CODE_SPACE, 1'b0);
        send_char(16'h0000, 1'b0);
        send_char(16'h2422, 1'b0);
        send_char(fwbm_pkg::CODE_HIRA_REP, 1'b0);
        send_char(fwbm_pkg::CODE_HIRA_WO, 1'b0);
        send_char(16'h2522, 1'b0);
        send_char(fwbm_pkg::CODE_LONG_VOWEL, 1'b0);
        send_char(fwbm_pkg::CODE_KATA_REP, 1'b0);
        send_char(16'h3000, 1'b0);
        send_char(fwbm_pkg::CODE_KANJI_REP, 1'b0);
        send_char(16'hffff, 1'b0);
        // reference parked on a long-vowel mark picks up the next character
        send_char(fwbm_pkg::CODE_LONG_VOWEL, 1'b1);
        send_char(16'h2423, 1'b0);
        send_char(16'h2330, 1'b0);
        send_char(fwbm_pkg::CODE_JSPACE, 1'b0);
        send_char(16'h2100, 1'b0);
        send_char(16'h0021, 1'b0);
        send_char(fwbm_pkg::CODE_TAB, 1'b0);
        send_char(16'h00ff, 1'b1);
        send_char(16'h0100, 1'b0);
        send_char(fwbm_pkg::CODE_KATA_REP_V, 1'b0);
        send_char(fwbm_pkg::CODE_HIRA_REP_V, 1'b0);
        send_char(16'h2fff, 1'b0);

        // one long paragraph, restart only on its first character, with no idling
        calm = 1'b1;
        send_char(pick_code(2), 1'b1);
        for (int i = 0; i < SAT_ITEMS; i++)
            send_char(pick_code($urandom_range(9)), 1'b0);
        calm = 1'b0;

        // word-shaped runs: mostly same-flavor characters, some noise between
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            flavor = $urandom_range(99) < 85 ? $urandom_range(8) : 9;
            run    = $urandom_range(6, 1);
            for (int k = 0; k < run; k++)
            begin
                send_char(pick_code(flavor), $urandom_range(99) < 4);
                sent++;
            end
        end
        in_valid <= 1'b0;

        while (board.stops_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (board.mismatches == 0 && board.stops_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fwbm_pkg.sv
rtl/core/fwbm_front.sv
rtl/core/fwbm_queue.sv
rtl/core/fwbm_back.sv
rtl/core/forward_word_boundary_marker.sv
rtl/core/fwbm_checker.sv
tb/tb.sv
